// File: hdl/ple_pkg.sv
// Shared types and constants for the positional list engine.
package ple_pkg;

  localparam int CMD_W  = 3;
  localparam int DATA_W = 32;
  localparam int POS_W  = 6;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_INSERT_AT  = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_BACK   = 3'd4,
    CMD_REMOVE_AT  = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic [CNT_W-1:0]         idx;
    logic signed [DATA_W-1:0] value;
  } shift_ctrl_t;

  typedef struct packed {
    shift_ctrl_t      shift;
    status_t          status;
    logic [CNT_W-1:0] count_nxt;
  } op_t;

endpackage

// File: hdl/ple_cell.sv
// One storage cell of the shifting entry chain.
module ple_cell
  import ple_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic                     clk,
  input  shift_ctrl_t              ctrl,
  input  logic signed [DATA_W-1:0] left_data,
  input  logic signed [DATA_W-1:0] right_data,
  output logic signed [DATA_W-1:0] data,
  output logic signed [DATA_W-1:0] tap
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic signed [DATA_W-1:0] data_r;
  logic                     hit;

  assign hit  = (ctrl.idx == MY_IDX);
  assign data = data_r;
  assign tap  = hit ? data_r : '0;

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (hit) begin
        data_r <= ctrl.value;
      end else if (MY_IDX > ctrl.idx) begin
        data_r <= left_data;
      end
    end else if (ctrl.rem) begin
      if (MY_IDX >= ctrl.idx) begin
        data_r <= right_data;
      end
    end
  end

endmodule

// File: hdl/ple_ctrl.sv
// Command decoder that checks limits and builds the shift controls for the cell chain.
module ple_ctrl
  import ple_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic [CMD_W-1:0]         command,
  input  logic signed [DATA_W-1:0] value,
  input  logic [POS_W-1:0]         position,
  input  logic [CNT_W-1:0]         count,
  output op_t                      op
);

  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

  logic             full;
  logic             empty;
  logic             ins_pos_ok;
  logic             rem_pos_ok;
  logic [CNT_W-1:0] pos_m1;

  assign full       = (count >= CAP);
  assign empty      = (count == '0);
  assign pos_m1     = CNT_W'(position - POS_W'(1));
  assign ins_pos_ok = (position != '0) && ({1'b0, position} <= ({1'b0, count} + 7'd1));
  assign rem_pos_ok = (position != '0) && (position <= count);

  always_comb begin
    op.shift.ins   = 1'b0;
    op.shift.rem   = 1'b0;
    op.shift.idx   = '0;
    op.shift.value = value;
    op.status      = ST_OK;
    unique case (command)
      CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT_AT: begin
        if (full) begin
          op.status = ST_FULL;
        end else if (command == CMD_PUSH_FRONT) begin
          op.shift.ins = 1'b1;
        end else if (command == CMD_PUSH_BACK) begin
          op.shift.ins = 1'b1;
          op.shift.idx = count;
        end else if (!ins_pos_ok) begin
          op.status = ST_RANGE;
        end else begin
          op.shift.ins = 1'b1;
          op.shift.idx = pos_m1;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK, CMD_REMOVE_AT: begin
        if (empty) begin
          op.status = ST_EMPTY;
        end else if (command == CMD_POP_FRONT) begin
          op.shift.rem = 1'b1;
        end else if (command == CMD_POP_BACK) begin
          op.shift.rem = 1'b1;
          op.shift.idx = count - CNT_W'(1);
        end else if (!rem_pos_ok) begin
          op.status = ST_RANGE;
        end else begin
          op.shift.rem = 1'b1;
          op.shift.idx = pos_m1;
        end
      end
      default: begin
        op.status = ST_OK;
      end
    endcase
    if (op.shift.ins) begin
      op.count_nxt = count + CNT_W'(1);
    end else if (op.shift.rem) begin
      op.count_nxt = count - CNT_W'(1);
    end else begin
      op.count_nxt = count;
    end
  end

endmodule

// File: hdl/positional_list_engine_core.sv
// Top level of the positional list engine: decoder, cell chain and result register.
// The engine keeps an ordered list of up to CAPACITY signed 32-bit entries in a row of
// cells that all shift in the same clock edge, so each insert or remove is done at once.
// A command is taken when start is high and busy is low; busy is high only while
// reset is applied and for the cycle after it. Exactly one result follows each command:
// out_strobe is high for one cycle, in the cycle after the command is taken, with status,
// removed value and new length. The receiver cannot stall, and a new command can be
// given in every cycle. There is no clearing pass after reset; only the count is cleared.
module positional_list_engine_core
  import ple_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [CMD_W-1:0]         in_command,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic [POS_W-1:0]         in_position,
  output logic                     out_strobe,
  output logic [STAT_W-1:0]        out_status,
  output logic signed [DATA_W-1:0] out_removed_value,
  output logic [CNT_W-1:0]         out_length
);

  logic                     busy_r;
  logic [CNT_W-1:0]         count_r;
  logic                     strobe_r;
  logic [STAT_W-1:0]        status_r;
  logic signed [DATA_W-1:0] removed_r;
  logic [CNT_W-1:0]         length_r;
  logic                     accept;
  op_t                      op;
  shift_ctrl_t              ctrl;
  logic signed [DATA_W-1:0] removed_nxt;
  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic signed [DATA_W-1:0] cell_tap  [CAPACITY];

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  ple_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .command  (in_command),
    .value    (in_value),
    .position (in_position),
    .count    (count_r),
    .op       (op)
  );

  always_comb begin
    ctrl     = op.shift;
    ctrl.ins = op.shift.ins && accept;
    ctrl.rem = op.shift.rem && accept;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ple_cell #(
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .left_data  ((i == 0) ? cell_data[0] : cell_data[(i == 0) ? 0 : i - 1]),
      .right_data ((i == CAPACITY - 1) ? cell_data[i] :
                   cell_data[(i == CAPACITY - 1) ? i : i + 1]),
      .data       (cell_data[i]),
      .tap        (cell_tap[i])
    );
  end

  always_comb begin
    removed_nxt = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      removed_nxt = removed_nxt | cell_tap[i];
    end
    if (!op.shift.rem) begin
      removed_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      busy_r   <= 1'b0;
      strobe_r <= accept;
      if (accept) begin
        count_r <= op.count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= op.status;
      removed_r <= removed_nxt;
      length_r  <= op.count_nxt;
    end
  end

  assign out_strobe        = strobe_r;
  assign out_status        = status_r;
  assign out_removed_value = removed_r;
  assign out_length        = length_r;

endmodule

// File: verif/positional_list_engine_core_test.sv
// Self-checking testbench for the positional list engine core.
`timescale 1ns / 100ps

module positional_list_engine_core_test
  import ple_pkg::*;
();

  localparam int LIST_CAPACITY = 32;
  localparam int MAX_REPORTS = 10;
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] removed;
    logic [CNT_W-1:0]         length;
  } list_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [CMD_W-1:0]         in_command;
  logic signed [DATA_W-1:0] in_value;
  logic [POS_W-1:0]         in_position;
  logic                     out_strobe;
  logic [STAT_W-1:0]        out_status;
  logic signed [DATA_W-1:0] out_removed_value;
  logic [CNT_W-1:0]         out_length;

  logic signed [DATA_W-1:0] list_model[$];
  list_result_t             pending_results[$];
  int                       failure_count;
  int                       items_sent;
  int                       results_checked;
  int                       peak_length;
  int                       sender_idle_pct;
  bit                       growing;

  positional_list_engine_core #(
    .CAPACITY(LIST_CAPACITY)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_command(in_command),
    .in_value(in_value),
    .in_position(in_position),
    .out_strobe(out_strobe),
    .out_status(out_status),
    .out_removed_value(out_removed_value),
    .out_length(out_length)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic list_result_t apply_list_command(logic [CMD_W-1:0] cmd,
                                                      logic signed [DATA_W-1:0] val,
                                                      logic [POS_W-1:0] pos);
    list_result_t r;
    int count;
    count = list_model.size();
    r.status = ST_OK;
    r.removed = '0;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT_AT: begin
        if (count >= LIST_CAPACITY) r.status = ST_FULL;
        else if (cmd == CMD_PUSH_FRONT) list_model.push_front(val);
        else if (cmd == CMD_PUSH_BACK) list_model.push_back(val);
        else if (pos < 1 || pos > count + 1) r.status = ST_RANGE;
        else list_model.insert(pos - 1, val);
      end
      CMD_POP_FRONT, CMD_POP_BACK, CMD_REMOVE_AT: begin
        if (count == 0) r.status = ST_EMPTY;
        else if (cmd == CMD_POP_FRONT) r.removed = list_model.pop_front();
        else if (cmd == CMD_POP_BACK) r.removed = list_model.pop_back();
        else if (pos < 1 || pos > count) r.status = ST_RANGE;
        else begin
          r.removed = list_model[pos - 1];
          list_model.delete(pos - 1);
        end
      end
      default: ;
    endcase
    r.length = CNT_W'(list_model.size());
    return r;
  endfunction

  task automatic send_item(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] val,
                           logic [POS_W-1:0] pos);
    int gap;
    start <= 1'b1;
    in_command <= cmd;
    in_value <= val;
    in_position <= pos;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_list_command(cmd, val, pos));
    items_sent++;
    if (list_model.size() > peak_length) peak_length = list_model.size();
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      in_command <= CMD_W'($urandom);
      in_value <= $urandom;
      in_position <= POS_W'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    list_result_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        failure_count++;
        if (failure_count <= MAX_REPORTS)
          $display("Unexpected result: status %0d removed %0d length %0d",
                   out_status, out_removed_value, out_length);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_status !== want.status || out_removed_value !== want.removed ||
            out_length !== want.length) begin
          failure_count++;
          if (failure_count <= MAX_REPORTS)
            $display("Mismatch on result %0d: expected status %0d removed %0d length %0d, %s",
                     results_checked, want.status, want.removed, want.length,
                     $sformatf("got status %0d removed %0d length %0d",
                               out_status, out_removed_value, out_length));
        end
      end
    end
  end

  task automatic test_edge_cases();
    send_item(CMD_POP_FRONT, $urandom, POS_W'($urandom));
    send_item(CMD_POP_BACK, $urandom, POS_W'($urandom));
    send_item(CMD_REMOVE_AT, $urandom, 6'd0);
    send_item(CMD_REMOVE_AT, $urandom, 6'd63);
    send_item(CMD_INSERT_AT, $urandom, 6'd0);
    send_item(CMD_INSERT_AT, $urandom, 6'd2);
    send_item(CMD_INSERT_AT, VALUE_MAX, 6'd1);
    send_item(CMD_PUSH_FRONT, VALUE_MIN, POS_W'($urandom));
    send_item(CMD_PUSH_BACK, -32'sd1, POS_W'($urandom));
    send_item(CMD_INSERT_AT, 32'sd0, 6'd4);
    send_item(CMD_INSERT_AT, 32'sh5555_5555, 6'd2);
    send_item(CMD_INSERT_AT, $urandom, 6'd63);
    send_item(CMD_REMOVE_AT, $urandom, 6'd0);
    send_item(CMD_REMOVE_AT, $urandom, 6'd6);
    send_item(CMD_REMOVE_AT, $urandom, 6'd3);
    send_item(CMD_SPARE_LO, $urandom, POS_W'($urandom));
    send_item(CMD_SPARE_HI, $urandom, POS_W'($urandom));
    send_item(CMD_POP_FRONT, $urandom, POS_W'($urandom));
    send_item(CMD_POP_BACK, $urandom, POS_W'($urandom));
    send_item(CMD_REMOVE_AT, $urandom, 6'd2);
    send_item(CMD_REMOVE_AT, $urandom, 6'd1);
    send_item(CMD_POP_BACK, $urandom, POS_W'($urandom));
    wait_for_results();
  endtask

  task automatic test_full_list();
    while (list_model.size() < LIST_CAPACITY) begin
      if ($urandom_range(1)) send_item(CMD_PUSH_BACK, $urandom, POS_W'($urandom));
      else send_item(CMD_PUSH_FRONT, $urandom, POS_W'($urandom));
    end
    send_item(CMD_PUSH_FRONT, $urandom, POS_W'($urandom));
    send_item(CMD_PUSH_BACK, $urandom, POS_W'($urandom));
    send_item(CMD_INSERT_AT, $urandom, 6'd0);
    send_item(CMD_INSERT_AT, $urandom, 6'd63);
    send_item(CMD_REMOVE_AT, $urandom, POS_W'(LIST_CAPACITY + 1));
    send_item(CMD_REMOVE_AT, $urandom, POS_W'(LIST_CAPACITY));
    send_item(CMD_INSERT_AT, VALUE_MAX, POS_W'(LIST_CAPACITY));
    send_item(CMD_REMOVE_AT, $urandom, 6'd1);
    send_item(CMD_INSERT_AT, VALUE_MIN, 6'd1);
    while (list_model.size() > 0) begin
      if ($urandom_range(1)) send_item(CMD_POP_BACK, $urandom, POS_W'($urandom));
      else send_item(CMD_POP_FRONT, $urandom, POS_W'($urandom));
    end
    wait_for_results();
  endtask

  task automatic test_random_traffic(int n, int idle_pct);
    int count;
    int pick;
    logic [CMD_W-1:0] cmd;
    logic signed [DATA_W-1:0] val;
    logic [POS_W-1:0] pos;
    sender_idle_pct = idle_pct;
    repeat (n) begin
      count = list_model.size();
      if (count == LIST_CAPACITY) growing = 1'b0;
      else if (count == 0) growing = 1'b1;
      else if ($urandom_range(99) < 3) growing = ~growing;
      pick = $urandom_range(99);
      val = ($urandom_range(7) == 0) ? ($urandom_range(1) ? VALUE_MAX : VALUE_MIN) : $urandom;
      pos = POS_W'($urandom);
      if (pick < 4) begin
        cmd = $urandom_range(1) ? CMD_SPARE_LO : CMD_SPARE_HI;
      end else if (growing ? pick < 70 : pick < 35) begin
        case ($urandom_range(2))
          0: cmd = CMD_PUSH_FRONT;
          1: cmd = CMD_PUSH_BACK;
          default: cmd = CMD_INSERT_AT;
        endcase
        if ($urandom_range(9) != 0) pos = POS_W'($urandom_range(count + 1, 1));
      end else begin
        case ($urandom_range(2))
          0: cmd = CMD_POP_FRONT;
          1: cmd = CMD_POP_BACK;
          default: cmd = CMD_REMOVE_AT;
        endcase
        if (count > 0 && $urandom_range(9) != 0) pos = POS_W'($urandom_range(count, 1));
      end
      send_item(cmd, val, pos);
    end
    wait_for_results();
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_command <= '0;
    in_value <= '0;
    in_position <= '0;
    failure_count = 0;
    items_sent = 0;
    results_checked = 0;
    peak_length = 0;
    sender_idle_pct = 0;
    growing = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_edge_cases();
    test_full_list();
    test_random_traffic(105, 15);
    test_random_traffic(105, 75);
    test_random_traffic(100, 0);

    $display("Sent %0d commands: edge cases, a fill to capacity and back, random traffic.",
             items_sent);
    $display("Checked %0d results; the list reached %0d entries.", results_checked,
             peak_length);
    if (failure_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: files.f
hdl/ple_pkg.sv
hdl/ple_cell.sv
hdl/ple_ctrl.sv
hdl/positional_list_engine_core.sv
verif/positional_list_engine_core_test.sv
